@@ rtl/lppd_pkg.sv @@
`timescale 1ns / 1ps

package lppd_pkg;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_EMPTY     = 2'd1,
		KIND_MALFORMED = 2'd2
	} kind_t;

	localparam logic [2:0]  HEADER_BYTES    = 3'd6;
	localparam logic [15:0] MIN_SIZE        = 16'd4;
	localparam logic [15:0] MAX_SIZE_RESET  = 16'd10240;

endpackage

@@ rtl/length_prefixed_packet_deframer_top.sv @@
`timescale 1ns / 1ps

// Deframes a received byte stream into packets, one byte per request.
// Each packet opens with a six-byte header: a big-endian 16-bit size and a
// little-endian 32-bit opcode. Payload bytes (size minus four of them) come
// out one per result, tagged with the low opcode bits and first/last marks.
// A packet without payload gives one completion result. A header whose size
// is below four, or whose size or opcode exceeds the limit max_size_q, gives a
// malformed result, and every later byte is reported malformed until reset.
// The input channel is data_byte with in_valid/in_stall; the output channel
// carries kind, opcode, payload_byte, first_byte, last_byte and
// payload_length with out_valid/out_stall. A taken byte waits in the input
// register and is decoded into the result register once the output is free.
// Header bytes give no result, but for the last byte of a malformed header
// or of a header without payload. One byte is taken per cycle as long as the
// output moves. When the receiver stalls, the result register holds and the
// input register fills, and in_stall rises once both are full. Reset clears
// the pipeline, the packet state, the sticky error and sets the limit to 10240.
module length_prefixed_packet_deframer_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lppd_pkg::kind_t       kind,
	output logic [15:0]           opcode,
	output logic [7:0]            payload_byte,
	output logic                  first_byte,
	output logic                  last_byte,
	output logic [15:0]           payload_length
);
	import lppd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [15:0] opcode_q;
	logic [7:0]  payload_byte_q;
	logic        first_q;
	logic        last_q;
	logic [15:0] payload_length_q;

	logic [15:0] max_size_q;
	logic [2:0]  header_count_q;
	logic [15:0] size_q;
	logic [31:0] opcode_acc_q;
	logic        in_payload_q;
	logic [15:0] remaining_q;
	logic        error_q;

	logic        out_free;
	logic        advance;
	logic        in_take;

	logic [2:0]  header_count_d;
	logic [15:0] size_d;
	logic [31:0] opcode_acc_d;
	logic        in_payload_d;
	logic [15:0] remaining_d;
	logic        error_d;
	logic        res_valid;
	kind_t       res_kind;
	logic [15:0] res_opcode;
	logic [7:0]  res_byte;
	logic        res_first;
	logic        res_last;
	logic [15:0] res_length;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		logic [15:0] plen;
		logic        bad;
		plen           = size_q - MIN_SIZE;
		bad            = 1'b0;
		header_count_d = header_count_q;
		size_d         = size_q;
		opcode_acc_d   = opcode_acc_q;
		in_payload_d   = in_payload_q;
		remaining_d    = remaining_q;
		error_d        = error_q;
		res_valid      = 1'b0;
		res_kind       = KIND_MALFORMED;
		res_opcode     = 16'd0;
		res_byte       = 8'd0;
		res_first      = 1'b0;
		res_last       = 1'b0;
		res_length     = 16'd0;
		if (error_q) begin
			res_valid = 1'b1;
		end else if (in_payload_q) begin
			res_valid  = 1'b1;
			res_kind   = KIND_PAYLOAD;
			res_opcode = opcode_acc_q[15:0];
			res_byte   = byte_s1;
			res_first  = (remaining_q == plen);
			res_last   = (remaining_q <= 16'd1);
			res_length = plen;
			if (res_last) begin
				header_count_d = 3'd0;
				size_d         = 16'd0;
				opcode_acc_d   = 32'd0;
				in_payload_d   = 1'b0;
				remaining_d    = 16'd0;
			end else begin
				remaining_d = remaining_q - 16'd1;
			end
		end else begin
			case (header_count_q)
				3'd0, 3'd1: size_d = {size_q[7:0], byte_s1};
				3'd2: opcode_acc_d[7:0]   = opcode_acc_q[7:0]   | byte_s1;
				3'd3: opcode_acc_d[15:8]  = opcode_acc_q[15:8]  | byte_s1;
				3'd4: opcode_acc_d[23:16] = opcode_acc_q[23:16] | byte_s1;
				3'd5: opcode_acc_d[31:24] = opcode_acc_q[31:24] | byte_s1;
				default: ;
			endcase
			header_count_d = header_count_q + 3'd1;
			if (header_count_d == HEADER_BYTES) begin
				bad = (size_d < MIN_SIZE) || (size_d > max_size_q) ||
					(opcode_acc_d[31:16] != 16'd0) || (opcode_acc_d[15:0] > max_size_q);
				res_valid = 1'b1;
				if (bad) begin
					error_d        = 1'b1;
					header_count_d = 3'd0;
					size_d         = 16'd0;
					opcode_acc_d   = 32'd0;
					remaining_d    = 16'd0;
				end else if (size_d == MIN_SIZE) begin
					res_kind       = KIND_EMPTY;
					res_opcode     = opcode_acc_d[15:0];
					res_last       = 1'b1;
					header_count_d = 3'd0;
					size_d         = 16'd0;
					opcode_acc_d   = 32'd0;
				end else begin
					res_valid      = 1'b0;
					in_payload_d   = 1'b1;
					remaining_d    = size_d - MIN_SIZE;
					header_count_d = 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			max_size_q     <= MAX_SIZE_RESET;
			header_count_q <= 3'd0;
			size_q         <= 16'd0;
			opcode_acc_q   <= 32'd0;
			in_payload_q   <= 1'b0;
			remaining_q    <= 16'd0;
			error_q        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_size_q <= cfg_wr_data;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				header_count_q <= header_count_d;
				size_q         <= size_d;
				opcode_acc_q   <= opcode_acc_d;
				in_payload_q   <= in_payload_d;
				remaining_q    <= remaining_d;
				error_q        <= error_d;
			end
			if (out_free) begin
				out_valid_q <= advance && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
		if (advance && res_valid) begin
			kind_q           <= res_kind;
			opcode_q         <= res_opcode;
			payload_byte_q   <= res_byte;
			first_q          <= res_first;
			last_q           <= res_last;
			payload_length_q <= res_length;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign opcode         = opcode_q;
	assign payload_byte   = payload_byte_q;
	assign first_byte     = first_q;
	assign last_byte      = last_q;
	assign payload_length = payload_length_q;

endmodule
